>>> rtl/mdr_pkg.sv
package mdr_pkg;

  // Quotient bits resolved per divider stage, and the number of divider stages.
  localparam int unsigned STEPS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES      = 64 / STEPS_PER_STAGE;

  // Work item carried down the divider pipeline.
  typedef struct packed {
    logic        ok;
    logic        neg;
    logic [6:0]  k;
    logic [63:0] mag;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] lo;
  } mdr_item_t;

endpackage

>>> rtl/mdr_req_if.sv
interface mdr_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] magic;
  logic [6:0]  shift;
  logic        wide;

  modport source (output valid, func, magic, shift, wide, input ready);
  modport sink   (input valid, func, magic, shift, wide, output ready);
endinterface

>>> rtl/mdr_rsp_if.sv
interface mdr_rsp_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [63:0] divisor_magnitude;
  logic        divisor_negative;

  modport source (output valid, valid_res, divisor_magnitude, divisor_negative, input ready);
  modport sink   (input valid, valid_res, divisor_magnitude, divisor_negative, output ready);
endinterface

>>> rtl/mdr_div_stage.sv
module mdr_div_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  mdr_pkg::mdr_item_t in_item,
  output logic               out_valid,
  output mdr_pkg::mdr_item_t out_item
);
  import mdr_pkg::*;

  mdr_item_t item_next;

  // Restoring division: shift one dividend bit in per step and subtract when it fits.
  always_comb begin
    logic [64:0] t;
    item_next = in_item;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      t = {item_next.rem, item_next.lo[63]};
      item_next.lo = {item_next.lo[62:0], 1'b0};
      if (t >= {1'b0, item_next.mag}) begin
        item_next.rem = 64'(t - {1'b0, item_next.mag});
        item_next.quo = {item_next.quo[62:0], 1'b1};
      end else begin
        item_next.rem = t[63:0];
        item_next.quo = {item_next.quo[62:0], 1'b0};
      end
    end
  end

  // Valid bit is control state; the payload loads with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end
endmodule

>>> rtl/magic_divisor_recovery_core.sv
// Pipeline from an accepted request to its response: decode register, 16 divider
// stages of 4 quotient bits each, final check and output register.
// Throughput: one transaction per cycle while rsp.ready is high; every stage advances
// on its own when the stage after it is free, so bubbles close up under back pressure.
// Reset: synchronous, active high; clears all stage valid bits. No other state.
module magic_divisor_recovery_core (
  input logic clk,
  input logic rst,
  mdr_req_if.sink   req,
  mdr_rsp_if.source rsp
);
  import mdr_pkg::*;

  logic                v_dec;
  mdr_item_t           dec_item;
  mdr_item_t           dec_next;
  logic [DIV_STAGES:0] v_div;
  mdr_item_t           div_item [DIV_STAGES+1];
  logic [DIV_STAGES:0] en_div;
  logic                en_dec;
  logic                en_out;

  // Per-stage load enables: a stage loads when it is empty or its successor loads.
  assign en_out = ~rsp.valid | rsp.ready;
  assign en_div[DIV_STAGES] = ~v_div[DIV_STAGES] | en_out;
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_en
    assign en_div[g] = ~v_div[g] | en_div[g+1];
  end
  assign en_dec    = en_div[0];
  assign req.ready = en_dec;

  // Decode: range checks, magnitude, exponent and initial partial remainder.
  always_comb begin
    logic        bad;
    logic [7:0]  e;
    logic [63:0] mag;
    logic [63:0] hi;
    bad = 1'b0;
    dec_next.neg = 1'b0;
    mag = req.magic;
    if (!req.func) begin
      bad = (req.shift > 7'd64) || (req.wide && req.shift > 7'd63);
      e = (req.wide ? 8'd64 : 8'd32) + {1'b0, req.shift};
    end else begin
      bad = req.shift > 7'd63;
      dec_next.neg = req.magic[63];
      mag = req.magic[63] ? 64'(~req.magic + 64'd1) : req.magic;
      bad = bad | mag[63];
      e = (req.wide ? 8'd63 : 8'd31) + {1'b0, req.shift};
    end
    hi = (e >= 8'd64) ? (64'd1 << e[5:0]) : 64'd0;
    // The quotient needs more than 64 bits exactly when the top half reaches the divisor.
    if (mag == 64'd0) bad = 1'b1;
    if (e >= 8'd64 && mag <= hi) bad = 1'b1;
    dec_next.ok  = ~bad;
    dec_next.k   = req.shift;
    dec_next.mag = bad ? 64'd1 : mag;
    dec_next.rem = bad ? 64'd0 : hi;
    dec_next.quo = 64'd0;
    dec_next.lo  = (e < 8'd64) ? (64'd1 << e[5:0]) : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dec <= 1'b0;
    end else if (en_dec) begin
      v_dec <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_dec) begin
      dec_item <= dec_next;
    end
  end

  assign v_div[0]    = v_dec;
  assign div_item[0] = dec_item;

  // Divider pipeline.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    mdr_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en_div[g+1]),
      .in_valid (v_div[g]),
      .in_item  (div_item[g]),
      .out_valid(v_div[g+1]),
      .out_item (div_item[g+1])
    );
  end

  // Final check: the remainder r gives M*K0 = 2^E - r and M*(K0+1) = 2^E + (M - r).
  logic        fin_ok;
  logic [63:0] fin_kd;
  always_comb begin
    mdr_item_t   it;
    logic [63:0] gap;
    logic        gap_fits;
    it = div_item[DIV_STAGES];
    gap = it.mag - it.rem;
    gap_fits = (it.k >= 7'd64) || ((gap >> it.k[5:0]) == 64'd0);
    fin_ok = it.ok && (it.quo >= 64'd2) &&
             ((it.rem == 64'd0) || ((it.quo != '1) && gap_fits));
    fin_kd = (it.rem == 64'd0) ? it.quo : 64'(it.quo + 64'd1);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en_out) begin
      rsp.valid <= v_div[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      rsp.valid_res         <= fin_ok;
      rsp.divisor_magnitude <= fin_ok ? fin_kd : 64'd0;
      rsp.divisor_negative  <= fin_ok & div_item[DIV_STAGES].neg;
    end
  end
endmodule

>>> rtl/mdr_checker.sv
module mdr_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        valid_res,
  input logic [63:0] divisor_magnitude,
  input logic        divisor_negative
);
  // A stalled response transaction stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // A stalled response keeps its divisor magnitude and valid_res flag.
  a_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(divisor_magnitude) && $stable(valid_res))
    else $error("response payload changed while stalled");

  // An invalid result reports a zero divisor.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !valid_res |-> divisor_magnitude == 64'd0 && !divisor_negative)
    else $error("invalid result with nonzero fields");

  // A valid divisor is at least two.
  a_min: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && valid_res |-> divisor_magnitude >= 64'd2)
    else $error("valid divisor below two");
endmodule

bind magic_divisor_recovery_core mdr_checker u_mdr_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .valid_res        (rsp.valid_res),
  .divisor_magnitude(rsp.divisor_magnitude),
  .divisor_negative (rsp.divisor_negative)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  typedef struct packed {
    logic        func;
    logic [63:0] magic;
    logic [6:0]  shift;
    logic        wide;
  } check_req_t;

  typedef struct packed {
    logic        valid_res;
    logic [63:0] divisor_magnitude;
    logic        divisor_negative;
  } divisor_rsp_t;

  localparam logic FUNC_UNSIGNED = 1'b0;
  localparam logic FUNC_SIGNED   = 1'b1;
  localparam logic WIDTH_32      = 1'b0;
  localparam logic WIDTH_64      = 1'b1;
  localparam int   LATENCY       = 18;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mdr_req_if req ();
  mdr_rsp_if rsp ();

  magic_divisor_recovery_core dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always #4 clk = ~clk;

  check_req_t   pending_reqs[$];
  divisor_rsp_t expected_divisors[$];
  int           n_errors   = 0;
  int           n_checked  = 0;
  int           n_valid    = 0;
  int           n_negative = 0;
  bit           hold_sender = 1'b0;
  int           burst_left = 0;
  int           gap_left   = 0;
  int           stall_phase = 0;

  // Check that magic*kd lies in [2^e, 2^e + 2^k).
  function automatic bit bound_holds(logic [63:0] mag, logic [63:0] kd, int e, int k);
    logic [127:0] prod;
    logic [127:0] low;
    logic [127:0] high;
    prod = 128'(mag) * 128'(kd);
    low  = 128'(1) << e;
    high = low + (128'(1) << k);
    return (prod >= low) && (prod < high);
  endfunction

  // Recover the divisor that a magic multiplier and shift stand for.
  function automatic divisor_rsp_t recover_divisor(check_req_t r);
    divisor_rsp_t res;
    logic [63:0]  mag;
    logic [127:0] quo;
    logic [63:0]  k0;
    logic [63:0]  kd;
    bit           ok;
    bit           neg;
    int           n;
    int           e;
    ok  = 1'b1;
    neg = 1'b0;
    mag = r.magic;
    n   = (r.wide == WIDTH_64) ? 64 : 32;
    kd  = '0;
    if (r.func == FUNC_UNSIGNED) begin
      if (r.shift > 64 || (n == 64 && r.shift > 63)) ok = 1'b0;
      e = n + r.shift;
    end else begin
      if (r.shift > 63) ok = 1'b0;
      neg = r.magic[63];
      mag = neg ? (~r.magic + 64'd1) : r.magic;
      if (mag[63]) ok = 1'b0;
      e = n - 1 + r.shift;
    end
    if (mag == 0) ok = 1'b0;
    if (ok) begin
      quo = (128'(1) << e) / 128'(mag);
      if (quo[127:64] != 0) ok = 1'b0;
      k0 = quo[63:0];
      if (ok && k0 < 2) ok = 1'b0;
    end
    if (ok) begin
      if (bound_holds(mag, k0, e, r.shift)) kd = k0;
      else if (k0 != '1 && bound_holds(mag, k0 + 64'd1, e, r.shift)) kd = k0 + 64'd1;
      else ok = 1'b0;
    end
    res.valid_res         = ok;
    res.divisor_magnitude = ok ? kd : 64'd0;
    res.divisor_negative  = ok && r.func == FUNC_SIGNED && neg;
    return res;
  endfunction

  // Build a well-formed magic for divisor d, so most checks pass the bound.
  function automatic check_req_t magic_for(logic [63:0] d, bit sgn, bit w, bit flip);
    check_req_t   r;
    logic [127:0] m;
    int           n;
    int           l;
    int           k;
    n = w ? 64 : 32;
    l = 0;
    while (l < 64 && (64'd1 << l) < d) l++;
    k = l + $urandom_range(0, 1);
    if (sgn && k > 63) k = 63;
    if (!sgn && k > (w ? 63 : 64)) k = w ? 63 : 64;
    m = ((128'(1) << (n - (sgn ? 1 : 0) + k)) / 128'(d)) + 128'(1);
    r.func  = sgn;
    r.wide  = w;
    r.shift = 7'(k);
    r.magic = m[63:0];
    if (sgn && flip) r.magic = ~r.magic + 64'd1;
    return r;
  endfunction

  function automatic check_req_t random_req();
    check_req_t r;
    r.func  = 1'($urandom);
    r.wide  = 1'($urandom);
    r.magic = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) r.magic = r.magic >> $urandom_range(0, 63);
    r.shift = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 66));
    return r;
  endfunction

  task automatic push_req(bit f, logic [63:0] m, int s, bit w);
    check_req_t r;
    r.func  = f;
    r.magic = m;
    r.shift = 7'(s);
    r.wide  = w;
    pending_reqs.push_back(r);
  endtask

  // Driver: bursts with random gaps; a transaction is accepted on valid and ready.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_divisors.push_back(recover_divisor({req.func, req.magic, req.shift,
                                                     req.wide}));
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_sender) begin
          check_req_t r;
          r = pending_reqs.pop_front();
          req.valid <= 1'b1;
          req.func  <= r.func;
          req.magic <= r.magic;
          req.shift <= r.shift;
          req.wide  <= r.wide;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: long free runs, then a window of random stalls.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready   <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 40) rsp.ready <= 1'b1;
      else if (stall_phase < 70) rsp.ready <= ($urandom_range(0, 2) != 0);
      else rsp.ready <= ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor: compare each response transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_divisors.size() == 0) begin
        $display("%0t: unexpected response res=%b mag=%h neg=%b", $time, rsp.valid_res,
                 rsp.divisor_magnitude, rsp.divisor_negative);
        n_errors++;
      end else begin
        divisor_rsp_t exp_rsp;
        exp_rsp = expected_divisors.pop_front();
        n_checked++;
        if (exp_rsp.valid_res) n_valid++;
        if (exp_rsp.divisor_negative) n_negative++;
        if (rsp.valid_res !== exp_rsp.valid_res) begin
          $display("%0t: valid_res expected %b actual %b", $time, exp_rsp.valid_res,
                   rsp.valid_res);
          n_errors++;
        end
        if (rsp.divisor_magnitude !== exp_rsp.divisor_magnitude) begin
          $display("%0t: divisor_magnitude expected %h actual %h", $time,
                   exp_rsp.divisor_magnitude, rsp.divisor_magnitude);
          n_errors++;
        end
        if (rsp.divisor_negative !== exp_rsp.divisor_negative) begin
          $display("%0t: divisor_negative expected %b actual %b", $time,
                   exp_rsp.divisor_negative, rsp.divisor_negative);
          n_errors++;
        end
      end
    end
  end

  // Stimulus: directed corner cases, then mostly well-formed magics plus noise.
  initial begin
    logic [63:0] d;
    req.func  = 1'b0;
    req.magic = '0;
    req.shift = '0;
    req.wide  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_req(FUNC_UNSIGNED, 64'hAAAA_AAAB, 1, WIDTH_32);
    push_req(FUNC_UNSIGNED, 64'hCCCC_CCCC_CCCC_CCCD, 2, WIDTH_64);
    push_req(FUNC_SIGNED, 64'h5555_5556, 0, WIDTH_32);
    push_req(FUNC_SIGNED, 64'hFFFF_FFFF_AAAA_AAAA, 0, WIDTH_32);
    push_req(FUNC_UNSIGNED, 64'd0, 0, WIDTH_32);
    push_req(FUNC_SIGNED, 64'd0, 3, WIDTH_64);
    push_req(FUNC_SIGNED, 64'h8000_0000_0000_0000, 0, WIDTH_64);
    push_req(FUNC_UNSIGNED, 64'd1, 0, WIDTH_64);
    push_req(FUNC_UNSIGNED, 64'd1, 64, WIDTH_32);
    push_req(FUNC_UNSIGNED, 64'd3, 65, WIDTH_32);
    push_req(FUNC_UNSIGNED, 64'd3, 64, WIDTH_64);
    push_req(FUNC_SIGNED, 64'd3, 64, WIDTH_32);
    push_req(FUNC_UNSIGNED, 64'd3, 127, WIDTH_64);
    push_req(FUNC_UNSIGNED, '1, 0, WIDTH_64);
    push_req(FUNC_UNSIGNED, '1, 63, WIDTH_64);
    push_req(FUNC_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 63, WIDTH_64);
    push_req(FUNC_SIGNED, 64'h8000_0000_0000_0001, 0, WIDTH_64);
    push_req(FUNC_UNSIGNED, 64'd2, 31, WIDTH_32);
    push_req(FUNC_UNSIGNED, 64'h8000_0001, 0, WIDTH_32);
    push_req(FUNC_UNSIGNED, 64'h1_0000_0001, 32, WIDTH_32);
    push_req(FUNC_SIGNED, 64'h2AAA_AAAB, 5, WIDTH_32);

    // Wait for the directed part to drain completely.
    while (pending_reqs.size() > 0 || req.valid || expected_divisors.size() > 0)
      @(posedge clk);

    for (int i = 0; i < 1950; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        pending_reqs.push_back(random_req());
      end else begin
        case ($urandom_range(0, 2))
          0: d = 64'($urandom_range(2, 1000));
          1: d = {32'd0, $urandom};
          default: d = {1'b0, 31'($urandom), $urandom} >> $urandom_range(0, 62);
        endcase
        if (d < 2) d = 2;
        pending_reqs.push_back(magic_for(d, 1'($urandom), 1'($urandom), 1'($urandom)));
      end
      // Once mid-run, hold the sender until every response has come back.
      if (i == 975) begin
        while (pending_reqs.size() > 0 || req.valid) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_divisors.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
    end

    while (pending_reqs.size() > 0 || req.valid || expected_divisors.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d divisor recoveries: %0d valid, %0d negative divisors,",
             n_checked, n_valid, n_negative);
    $display("covering both widths, signed and unsigned, and out-of-range shifts.");
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

>>> magic_divisor_recovery_core.f
rtl/mdr_pkg.sv
rtl/mdr_req_if.sv
rtl/mdr_rsp_if.sv
rtl/mdr_div_stage.sv
rtl/magic_divisor_recovery_core.sv
rtl/mdr_checker.sv
tb/sv/testbench.sv
